FILE: sv/bls_pkg.sv
// ---------------------------------------------------------------------------
// bls_pkg
// Shared constants, operation codes and control structs for the Bresenham
// line stepper.
// ---------------------------------------------------------------------------
package bls_pkg;

   // default configuration
   localparam int COORD_BITS_DEF       = 13;
   localparam int WEIGHT_FRAC_BITS_DEF = 16;

   // operation codes carried in the request tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // sequencer commands to the stepping datapath
   typedef struct packed {
      logic load;      // latch new endpoints
      logic advance;   // move to the next pixel
   } step_ctrl_type;

   // status of the divider
   typedef struct packed {
      logic busy;      // iterating
      logic done;      // quotient held and valid
   } div_stat_type;

endpackage

FILE: sv/bls_stepper.sv
// ---------------------------------------------------------------------------
// bls_stepper
// Bresenham state: current position, spans, error accumulator, step
// directions and the remaining major-axis distance.
// ---------------------------------------------------------------------------
module bls_stepper
   import bls_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  step_ctrl_type         ctrl,
   input  logic [COORD_BITS-1:0] start_x,
   input  logic [COORD_BITS-1:0] start_y,
   input  logic [COORD_BITS-1:0] end_x,
   input  logic [COORD_BITS-1:0] end_y,
   output logic [COORD_BITS-1:0] cur_x,
   output logic [COORD_BITS-1:0] cur_y,
   output logic [COORD_BITS:0]   remaining,
   output logic [COORD_BITS:0]   span,
   output logic                  last,
   output logic                  active
);

   localparam int SPAN_W = COORD_BITS + 1;
   localparam int ERR_W  = COORD_BITS + 4;

   logic [COORD_BITS-1:0]   cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]   cur_y_ff, cur_y_in;
   logic [SPAN_W-1:0]       major_ff, major_in;
   logic [SPAN_W-1:0]       minor_ff, minor_in;
   logic [SPAN_W-1:0]       rem_ff, rem_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic                    x_major_ff, x_major_in;
   logic                    neg_x_ff, neg_x_in;
   logic                    neg_y_ff, neg_y_in;
   logic                    active_ff, active_in;

   logic signed [SPAN_W-1:0] dx, dy;
   logic [SPAN_W-1:0]        adx, ady;
   logic                     ld_x_major;
   logic signed [ERR_W-1:0]  err_add, err_twice, major_ext;
   logic                     overflow;
   logic [COORD_BITS-1:0]    step_x, step_y;

   // endpoint deltas on load
   always_comb begin
      dx  = $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
      dy  = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
      adx = dx[SPAN_W-1] ? SPAN_W'(-dx) : SPAN_W'(dx);
      ady = dy[SPAN_W-1] ? SPAN_W'(-dy) : SPAN_W'(dy);
      ld_x_major = adx > ady;
   end

   // error update and unit steps
   always_comb begin
      major_ext = $signed({{(ERR_W-SPAN_W){1'b0}}, major_ff});
      err_add   = err_ff + $signed({{(ERR_W-SPAN_W){1'b0}}, minor_ff});
      err_twice = err_add <<< 1;
      overflow  = err_twice > major_ext;
      step_x    = neg_x_ff ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
      step_y    = neg_y_ff ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
   end

   // next state
   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      rem_in     = rem_ff;
      err_in     = err_ff;
      x_major_in = x_major_ff;
      neg_x_in   = neg_x_ff;
      neg_y_in   = neg_y_ff;
      active_in  = active_ff;
      if (ctrl.load) begin
         cur_x_in   = start_x;
         cur_y_in   = start_y;
         x_major_in = ld_x_major;
         neg_x_in   = dx[SPAN_W-1];
         neg_y_in   = dy[SPAN_W-1];
         major_in   = ld_x_major ? adx : ady;
         minor_in   = ld_x_major ? ady : adx;
         rem_in     = ld_x_major ? adx : ady;
         err_in     = '0;
         active_in  = (ld_x_major ? adx : ady) != '0;
      end else if (ctrl.advance) begin
         err_in = overflow ? err_add - major_ext : err_add;
         if (x_major_ff) begin
            cur_x_in = cur_x_ff + step_x;
            if (overflow) cur_y_in = cur_y_ff + step_y;
         end else begin
            cur_y_in = cur_y_ff + step_y;
            if (overflow) cur_x_in = cur_x_ff + step_x;
         end
         rem_in = rem_ff - SPAN_W'(1);
         if (last) active_in = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         major_ff   <= '0;
         minor_ff   <= '0;
         rem_ff     <= '0;
         err_ff     <= '0;
         x_major_ff <= 1'b0;
         neg_x_ff   <= 1'b0;
         neg_y_ff   <= 1'b0;
         active_ff  <= 1'b0;
      end else begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         major_ff   <= major_in;
         minor_ff   <= minor_in;
         rem_ff     <= rem_in;
         err_ff     <= err_in;
         x_major_ff <= x_major_in;
         neg_x_ff   <= neg_x_in;
         neg_y_ff   <= neg_y_in;
         active_ff  <= active_in;
      end
   end

   assign cur_x     = cur_x_ff;
   assign cur_y     = cur_y_ff;
   assign remaining = rem_ff;
   assign span      = major_ff;
   assign last      = rem_ff <= SPAN_W'(1);
   assign active    = active_ff;

endmodule

FILE: sv/bls_divider.sv
// ---------------------------------------------------------------------------
// bls_divider
// Restoring divider, one quotient bit per cycle: weight = floor(rem * 2^F /
// span), valid for rem <= span, span non-zero.
// ---------------------------------------------------------------------------
module bls_divider
   import bls_pkg::*;
#(
   parameter int COORD_BITS       = COORD_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        clear,
   input  logic [COORD_BITS:0]         dividend,
   input  logic [COORD_BITS:0]         divisor,
   output div_stat_type                status,
   output logic [WEIGHT_FRAC_BITS:0]   quotient
);

   localparam int SPAN_W = COORD_BITS + 1;
   localparam int Q_W    = WEIGHT_FRAC_BITS + 1;
   localparam int CNT_W  = $clog2(Q_W);

   logic [SPAN_W:0]   rem_ff, rem_in;
   logic [SPAN_W-1:0] div_ff, div_in;
   logic [Q_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic              ge;
   logic [SPAN_W:0]   diff;

   // compare and subtract
   always_comb begin
      ge   = rem_ff >= {1'b0, div_ff};
      diff = ge ? rem_ff - {1'b0, div_ff} : rem_ff;
   end

   // iteration control
   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = {1'b0, dividend};
         div_in  = divisor;
         quo_in  = '0;
         cnt_in  = CNT_W'(WEIGHT_FRAC_BITS);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = {diff[SPAN_W-1:0], 1'b0};
         quo_in = {quo_ff[Q_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (clear) begin
         done_in = 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

FILE: sv/bresenham_line_stepper_core.sv
// ---------------------------------------------------------------------------
// bresenham_line_stepper_core
// Integer Bresenham line rasteriser with a per-pixel interpolation weight.
// ---------------------------------------------------------------------------
// A load beat (tuser = 0) latches both endpoints and gives no output.
// Each step beat (tuser = 1) emits the current pixel with its weight,
// floor(remaining * 2^WEIGHT_FRAC_BITS / major span), and tlast on the final
// pixel; the end point itself is never emitted, and a step with no line in
// progress is swallowed. A step holds the input from its accept to the
// earliest next accept: it is accepted, the restoring divider forms the
// weight (one quotient bit a cycle), and the output register is written
// once it is empty or the receiver takes the pixel it holds.
// A finished pixel waits in the output register while the next beat is taken.
module bresenham_line_stepper_core
   import bls_pkg::*;
#(
   parameter int COORD_BITS       = COORD_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
   localparam int REQ_W = ((4 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * COORD_BITS + WEIGHT_FRAC_BITS + 1 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // start_x, start_y, end_x, end_y
   input  logic [0:0]       req_tuser,   // operation
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // pixel_x, pixel_y, weight
   output logic             rsp_tlast    // last_pixel
);

   localparam int C      = COORD_BITS;
   localparam int Q_W    = WEIGHT_FRAC_BITS + 1;
   localparam int PAY_W  = 2 * C + Q_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PAY_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   step_ctrl_type    step_ctrl;
   div_stat_type     div_stat;
   logic             accept, div_start, finish;
   logic [C-1:0]     cur_x, cur_y;
   logic [C:0]       remaining, span;
   logic             last, active;
   logic [Q_W-1:0]   weight;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign div_start  = accept && (req_tuser[0] == OP_STEP) && active;
   assign finish     = (state_ff == ST_BUSY) && div_stat.done && (!rsp_valid_ff || rsp_tready);

   assign step_ctrl.load    = accept && (req_tuser[0] == OP_LOAD);
   assign step_ctrl.advance = finish;

   // bresenham state
   bls_stepper #(
      .COORD_BITS (COORD_BITS)
   ) u_stepper (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (step_ctrl),
      .start_x   (req_tdata[C-1:0]),
      .start_y   (req_tdata[2*C-1:C]),
      .end_x     (req_tdata[3*C-1:2*C]),
      .end_y     (req_tdata[4*C-1:3*C]),
      .cur_x     (cur_x),
      .cur_y     (cur_y),
      .remaining (remaining),
      .span      (span),
      .last      (last),
      .active    (active)
   );

   // weight divider
   bls_divider #(
      .COORD_BITS       (COORD_BITS),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .clear    (finish),
      .dividend (remaining),
      .divisor  (span),
      .status   (div_stat),
      .quotient (weight)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (div_start) state_in = ST_BUSY;
         ST_BUSY: if (finish) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {weight, cur_y, cur_x};
         rsp_last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-PAY_W){1'b0}}, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: tb/bresenham_line_stepper_checker.sv
// ---------------------------------------------------------------------------
// bresenham_line_stepper_checker
// Watches both streams of the line stepper, predicts every pixel from the
// accepted request beats and compares each response beat with the oldest
// predicted pixel, field by field.
// ---------------------------------------------------------------------------
module bresenham_line_stepper_checker
   import bls_pkg::*;
#(
   localparam int COORD_W  = COORD_BITS_DEF,
   localparam int WFRAC    = WEIGHT_FRAC_BITS_DEF,
   localparam int WEIGHT_W = WEIGHT_FRAC_BITS_DEF + 1,
   localparam int REQ_W    = ((4 * COORD_W + 7) / 8) * 8,
   localparam int RSP_W    = ((2 * COORD_W + WEIGHT_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // start_x, start_y, end_x, end_y
   input  logic [0:0]       req_tuser,   // operation
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,   // pixel_x, pixel_y, weight
   input  logic             rsp_tlast,   // last_pixel
   output int               fail_count,
   output int               outstanding,
   output int               lines_loaded,
   output int               pixels_checked
);

   typedef struct packed {
      logic [COORD_W-1:0]  px;
      logic [COORD_W-1:0]  py;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
   } pixel_type;

   // predicted pixels, oldest first
   pixel_type expected_pixels[$];

   // shadow of the stepper state
   int   pos_x = 0, pos_y = 0, tgt_x = 0, tgt_y = 0;
   int   major_len = 0, minor_len = 0, err_acc = 0;
   logic along_x = 1'b0, neg_x = 1'b0, neg_y = 1'b0, drawing = 1'b0;

   int failures = 0;
   int loads    = 0;
   int checked  = 0;

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // apply one request beat to the shadow state, queueing any pixel it emits
   task automatic trace_beat(input logic op, input logic [REQ_W-1:0] data);
      int        sx, sy, ex, ey, adx, ady, remaining;
      longint    quotient;
      pixel_type pix;
      if (op == OP_LOAD) begin
         sx = $signed(data[COORD_W-1:0]);
         sy = $signed(data[2*COORD_W-1:COORD_W]);
         ex = $signed(data[3*COORD_W-1:2*COORD_W]);
         ey = $signed(data[4*COORD_W-1:3*COORD_W]);
         adx = magnitude(ex - sx);
         ady = magnitude(ey - sy);
         pos_x = sx;
         pos_y = sy;
         tgt_x = ex;
         tgt_y = ey;
         neg_x = ex < sx;
         neg_y = ey < sy;
         // ties go to the y axis
         along_x = adx > ady;
         major_len = along_x ? adx : ady;
         minor_len = along_x ? ady : adx;
         err_acc = 0;
         drawing = major_len != 0;
         loads++;
      end else if (drawing) begin
         remaining = along_x ? magnitude(tgt_x - pos_x) : magnitude(tgt_y - pos_y);
         quotient = (longint'(remaining) << WFRAC) / major_len;
         pix.px = pos_x[COORD_W-1:0];
         pix.py = pos_y[COORD_W-1:0];
         pix.weight = quotient[WEIGHT_W-1:0];
         pix.last = remaining <= 1;
         expected_pixels.push_back(pix);
         // advance along the major axis, minor axis on error overflow
         err_acc += minor_len;
         if (along_x) begin
            pos_x += neg_x ? -1 : 1;
            if (2 * err_acc > major_len) begin
               pos_y += neg_y ? -1 : 1;
               err_acc -= major_len;
            end
         end else begin
            pos_y += neg_y ? -1 : 1;
            if (2 * err_acc > major_len) begin
               pos_x += neg_x ? -1 : 1;
               err_acc -= major_len;
            end
         end
         if (pix.last) drawing = 1'b0;
      end
   endtask

   // compare one response beat with the oldest predicted pixel
   task automatic check_pixel();
      pixel_type want, got;
      got.px = rsp_tdata[COORD_W-1:0];
      got.py = rsp_tdata[2*COORD_W-1:COORD_W];
      got.weight = rsp_tdata[2*COORD_W+WEIGHT_W-1:2*COORD_W];
      got.last = rsp_tlast;
      if (expected_pixels.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected pixel beat: x=%0d y=%0d w=%0d last=%0b",
                     $signed(got.px), $signed(got.py), got.weight, got.last);
      end else begin
         want = expected_pixels.pop_front();
         checked++;
         if (got.px !== want.px || got.py !== want.py ||
             got.weight !== want.weight || got.last !== want.last) begin
            failures++;
            if (failures <= 10)
               $display("pixel %0d: exp %0d,%0d w=%0d l=%0b got %0d,%0d w=%0d l=%0b",
                        checked, $signed(want.px), $signed(want.py), want.weight,
                        want.last, $signed(got.px), $signed(got.py), got.weight,
                        got.last);
         end
      end
   endtask

   // sample both streams at the clock edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) trace_beat(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) check_pixel();
      end
      fail_count <= failures;
      outstanding <= expected_pixels.size();
      lines_loaded <= loads;
      pixels_checked <= checked;
   end

endmodule

FILE: tb/bresenham_line_stepper_core_tb.sv
// ---------------------------------------------------------------------------
// bresenham_line_stepper_core_tb
// Drives load and step beats into the line stepper: a directed opening on
// extreme, degenerate and replaced lines, then random lines stepped to the
// end or broken off, under bursty input and a stalling receiver.
// ---------------------------------------------------------------------------
module bresenham_line_stepper_core_tb;
   import bls_pkg::*;

   localparam int COORD_W   = COORD_BITS_DEF;
   localparam int REQ_W     = ((4 * COORD_W + 7) / 8) * 8;
   localparam int RSP_W     = ((2 * COORD_W + WEIGHT_FRAC_BITS_DEF + 1 + 7) / 8) * 8;
   localparam int ITEM_GOAL = 1310;
   localparam int LIMIT     = 400000;
   localparam int HOLD_LEN  = 400;
   localparam int COORD_MIN = -(1 << (COORD_W - 1));
   localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // start_x, start_y, end_x, end_y
   logic [0:0]       req_tuser = OP_LOAD;   // operation
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;   // pixel_x, pixel_y, weight
   logic             rsp_tlast;   // last_pixel

   int fail_count, outstanding, lines_loaded, pixels_checked;

   int   cycle_count = 0;
   int   items_sent = 0;
   int   idle_steps = 0;
   int   pixels_left = 0;
   int   burst_left = 0;
   logic stall_hold = 1'b0;
   int   ready_mode = 0;
   int   mode_timer = 0;

   always #1 clock = ~clock;

   bresenham_line_stepper_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   bresenham_line_stepper_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .lines_loaded   (lines_loaded),
      .pixels_checked (pixels_checked)
   );

   // receiver: ready pattern changes to a random mode whenever its timer runs out
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_timer == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_timer = $urandom_range(20, 80);
         end
         mode_timer--;
         if (stall_hold) begin
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom_range(0, 3) != 0;
               2: rsp_tready <= $urandom_range(0, 3) == 0;
               default: rsp_tready <= (cycle_count % 5) != 0;
            endcase
         end
      end
   end

   // long receiver hold-off once the random part is well under way
   initial begin
      while (items_sent < 600) @(posedge clock);
      stall_hold <= 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      stall_hold <= 1'b0;
   end

   // cycle counter and watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < LIMIT) @(posedge clock);
      $display("bresenham_line_stepper_core_tb NOT OK");
      $finish;
   end

   function automatic logic [REQ_W-1:0] pack_ends(input int sx, input int sy,
                                                  input int ex, input int ey);
      logic [REQ_W-1:0] d;
      d = '0;
      d[COORD_W-1:0] = sx[COORD_W-1:0];
      d[2*COORD_W-1:COORD_W] = sy[COORD_W-1:0];
      d[3*COORD_W-1:2*COORD_W] = ex[COORD_W-1:0];
      d[4*COORD_W-1:3*COORD_W] = ey[COORD_W-1:0];
      return d;
   endfunction

   function automatic int fold_coord(input int base, input int delta);
      if (base + delta > COORD_MAX || base + delta < COORD_MIN) return base - delta;
      return base + delta;
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
   endfunction

   // one beat on the request side, with bursts and random gaps
   task automatic send_beat(input logic op, input logic [REQ_W-1:0] data);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         // a stretch with no idling in the middle of the run
         if (items_sent >= 900 && items_sent < 1050) gap = 0;
         else gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load_line(input int sx, input int sy, input int ex, input int ey);
      int adx, ady;
      adx = (ex > sx) ? ex - sx : sx - ex;
      ady = (ey > sy) ? ey - sy : sy - ey;
      pixels_left = (adx > ady) ? adx : ady;
      items_sent++;
      send_beat(OP_LOAD, pack_ends(sx, sy, ex, ey));
   endtask

   // step beats carry random data, which the block must ignore
   task automatic step_pixel();
      logic [63:0] noise;
      logic [REQ_W-1:0] d;
      noise = {$urandom, $urandom};
      d = '0;
      d[4*COORD_W-1:0] = noise[4*COORD_W-1:0];
      if (pixels_left > 0) begin
         pixels_left--;
         items_sent++;
      end else begin
         idle_steps++;
      end
      send_beat(OP_STEP, d);
   endtask

   // stimulus and verdict
   initial begin
      int sx, sy, ex, ey, reach, dx, dy, span, steps, pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // step with no line since reset
      step_pixel();
      // zero-length line, then a step that gives nothing
      load_line(5, 5, 5, 5);
      step_pixel();
      // extreme corners, diagonal tie goes y-major, broken off
      load_line(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
      step_pixel();
      step_pixel();
      // extreme x-major run, broken off
      load_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN + 6);
      step_pixel();
      // horizontal line, minor span zero, then one step past its end
      load_line(0, 0, 3, 0);
      repeat (4) step_pixel();
      // y-major, both directions negative
      load_line(2, 1, 0, -3);
      repeat (4) step_pixel();
      // new line replaces one in progress
      load_line(10, 10, 20, 13);
      repeat (2) step_pixel();
      load_line(-3, 7, -3, 5);
      repeat (3) step_pixel();

      // random lines
      while (items_sent < ITEM_GOAL) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            step_pixel();
         end else if (pick < 10) begin
            sx = rand_coord();
            sy = rand_coord();
            load_line(sx, sy, sx, sy);
         end else if (pick < 14) begin
            load_line(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            repeat ($urandom_range(1, 4)) step_pixel();
         end else begin
            reach = ($urandom_range(0, 9) == 0) ? 64 : 12;
            sx = rand_coord();
            sy = rand_coord();
            dx = int'($urandom_range(0, 2 * reach)) - reach;
            dy = int'($urandom_range(0, 2 * reach)) - reach;
            ex = fold_coord(sx, dx);
            ey = fold_coord(sy, dy);
            load_line(sx, sy, ex, ey);
            span = pixels_left;
            if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, span);
            else steps = span + (($urandom_range(0, 6) == 0) ? 1 : 0);
            repeat (steps) step_pixel();
         end
      end
      req_tvalid <= 1'b0;

      // drain, then let the block settle
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("run covered %0d line loads, %0d checked pixels, %0d steps with no line",
               lines_loaded, pixels_checked, idle_steps);
      $display("bursty input with gaps, varied receiver stalls and a %0d-cycle hold-off",
               HOLD_LEN);
      if (fail_count == 0 && outstanding == 0) begin
         $display("bresenham_line_stepper_core_tb OK");
      end else begin
         $display("bresenham_line_stepper_core_tb NOT OK");
      end
      $finish;
   end

endmodule
